/* hdl/sca_pkg.sv */
// Shared types, constants and codes for the sparse coordinate assembly table.
package sca_pkg;

    localparam int CAPACITY   = 1024;
    localparam int INDEX_BITS = 16;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int KEY_W      = 2 * INDEX_BITS;
    localparam int SIZE_W     = 17;
    localparam int VAL_W      = 64;

    typedef enum logic [2:0] {
        CMD_INSERT     = 3'd0,
        CMD_INSERT_ADD = 3'd1,
        CMD_READ       = 3'd2,
        CMD_CLEAR      = 3'd3,
        CMD_SCATTER    = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        STS_FOUND    = 3'd0,
        STS_CREATED  = 3'd1,
        STS_ABSENT   = 3'd2,
        STS_FULL     = 3'd3,
        STS_FILTERED = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_KEY_RD,
        ST_KEY_CMP,
        ST_MISS,
        ST_VAL_RD,
        ST_VAL_UPD,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic [2:0]              command;
        logic [15:0]             row;
        logic [15:0]             col;
        logic signed [VAL_W-1:0] value;
        logic [3:0]              local_row;
        logic [3:0]              local_col;
        logic                    values_symmetric;
    } t_cmd_item;

    typedef struct packed {
        logic [ADDR_W-1:0]       entry_index;
        logic signed [VAL_W-1:0] read_value;
        logic [2:0]              status;
        logic [SIZE_W-1:0]       matrix_size;
        logic [CNT_W-1:0]        entry_count;
    } t_result;

endpackage

/* hdl/sca_sat_add.sv */
// Saturating 64-bit adder for Q32.32 accumulation.
module sca_sat_add
    import sca_pkg::*;
(
    input  logic signed [VAL_W-1:0] i_a,
    input  logic signed [VAL_W-1:0] i_b,
    output logic signed [VAL_W-1:0] o_sum
);

    logic [VAL_W-1:0] raw;
    logic             ovf;

    // add, then clamp when both operands share a sign that the sum lost
    always_comb begin
        raw = i_a + i_b;
        ovf = (i_a[VAL_W-1] == i_b[VAL_W-1]) && (raw[VAL_W-1] != i_a[VAL_W-1]);
        if (ovf) begin
            o_sum = i_a[VAL_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end else begin
            o_sum = raw;
        end
    end

endmodule

/* hdl/sparse_coo_assembly_table_core.sv */
// Top level of the sparse coordinate assembly table: sequencer, key and value memories.
//
//  channel   direction  handshake                 payload
//  command   in         start high, busy low      i_item   (t_cmd_item)
//  result    out        o_done, one-cycle strobe  o_result (t_result)
//  config    in         i_cfg_valid, o_cfg_ready  i_cfg_data (matrix_symmetric)
//
// An item that scans the key memory probes the stored entries one at a time, each with a
// read and then a compare, through the single key read port. A hit ends the scan at that
// entry; a miss scans all stored entries. Clear, filtered scatter and unused codes skip
// the scan. Reset empties the profile at once (count and size to zero); the memories need
// no clearing. The receiver cannot stall: each result is shown for one cycle while the
// next item may already be accepted.
module sparse_coo_assembly_table_core
    import sca_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_cmd_item i_item,
    output logic      o_done,
    output t_result   o_result,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_data
);

    logic [KEY_W-1:0] key_mem [CAPACITY];
    logic [VAL_W-1:0] val_mem [CAPACITY];

    t_state            r_state, n_state;
    t_cmd_item         r_in, n_in;
    logic [CNT_W-1:0]  r_ptr, n_ptr;
    logic [CNT_W-1:0]  r_pos, n_pos;
    logic              r_created, n_created;
    logic [2:0]        r_status, n_status;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic [VAL_W-1:0]  r_rv, n_rv;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [SIZE_W-1:0] r_size, n_size;
    logic              r_sym, n_sym;
    t_result           r_out, n_out;
    logic              r_out_vld, n_out_vld;
    logic [KEY_W-1:0]  r_key_rd;
    logic [VAL_W-1:0]  r_mem_val;

    logic [KEY_W-1:0]  key;
    logic              keep;
    logic              last;
    logic              search_cmd;
    logic              full;
    logic              key_we;
    logic              val_we;
    logic [VAL_W-1:0]  add_a;
    logic [VAL_W-1:0]  add_sum;
    logic [SIZE_W-1:0] row_p1;
    logic [SIZE_W-1:0] col_p1;

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_done      = r_out_vld;
    assign o_result    = r_out;

    // decode helpers
    always_comb begin
        key    = {r_in.row[INDEX_BITS-1:0], r_in.col[INDEX_BITS-1:0]};
        row_p1 = SIZE_W'(r_in.row[INDEX_BITS-1:0]) + SIZE_W'(1);
        col_p1 = SIZE_W'(r_in.col[INDEX_BITS-1:0]) + SIZE_W'(1);
        keep   = (SIZE_W'(r_in.row) < r_size) && (SIZE_W'(r_in.col) < r_size);
        if (keep && r_sym) begin
            if (r_in.values_symmetric) begin
                keep = (r_in.local_col >= r_in.local_row);
            end else begin
                keep = (r_in.col >= r_in.row);
            end
        end
        last       = ((r_ptr + CNT_W'(1)) == r_count);
        full       = (r_count == CNT_W'(CAPACITY));
        search_cmd = (r_in.command == CMD_INSERT) || (r_in.command == CMD_INSERT_ADD);
        add_a      = r_created ? '0 : r_mem_val;
    end

    sca_sat_add u_add (
        .i_a   (add_a),
        .i_b   (r_in.value),
        .o_sum (add_sum)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                case (r_in.command)
                    CMD_INSERT, CMD_INSERT_ADD, CMD_READ:
                        n_state = (r_count == '0) ? ST_MISS : ST_KEY_RD;
                    CMD_SCATTER: begin
                        if (!keep) n_state = ST_RESP;
                        else n_state = (r_count == '0) ? ST_MISS : ST_KEY_RD;
                    end
                    default: n_state = ST_RESP;
                endcase
            end
            ST_KEY_RD: n_state = ST_KEY_CMP;
            ST_KEY_CMP: begin
                if (r_key_rd == key) n_state = ST_VAL_RD;
                else if (last) n_state = ST_MISS;
                else n_state = ST_KEY_RD;
            end
            ST_MISS: begin
                if (search_cmd && !full) n_state = ST_VAL_UPD;
                else n_state = ST_RESP;
            end
            ST_VAL_RD:  n_state = ST_VAL_UPD;
            ST_VAL_UPD: n_state = ST_RESP;
            ST_RESP:    n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_in      = r_in;
        n_ptr     = r_ptr;
        n_pos     = r_pos;
        n_created = r_created;
        n_status  = r_status;
        n_idx     = r_idx;
        n_rv      = r_rv;
        n_count   = r_count;
        n_size    = r_size;
        n_sym     = r_sym;
        n_out     = r_out;
        n_out_vld = 1'b0;
        key_we    = 1'b0;
        val_we    = 1'b0;
        if (i_cfg_valid && o_cfg_ready) n_sym = i_cfg_data;
        case (r_state)
            ST_IDLE: begin
                if (start) n_in = i_item;
            end
            ST_DECODE: begin
                n_ptr     = '0;
                n_created = 1'b0;
                n_idx     = '0;
                n_rv      = '0;
                n_status  = STS_FILTERED;
                if (r_in.command == CMD_CLEAR) begin
                    n_count  = '0;
                    n_size   = '0;
                    n_status = STS_FOUND;
                end
            end
            ST_KEY_CMP: begin
                if (r_key_rd == key) n_pos = r_ptr;
                else n_ptr = r_ptr + CNT_W'(1);
            end
            ST_MISS: begin
                if (!search_cmd) begin
                    n_status = STS_ABSENT;
                end else if (full) begin
                    n_status = STS_FULL;
                end else begin
                    key_we    = 1'b1;
                    n_pos     = r_count;
                    n_count   = r_count + CNT_W'(1);
                    n_created = 1'b1;
                    n_size    = r_size;
                    if (row_p1 > n_size) n_size = row_p1;
                    if (col_p1 > n_size) n_size = col_p1;
                end
            end
            ST_VAL_UPD: begin
                val_we   = 1'b1;
                n_idx    = r_pos[ADDR_W-1:0];
                n_status = r_created ? STS_CREATED : STS_FOUND;
                if ((r_in.command == CMD_INSERT_ADD) || (r_in.command == CMD_SCATTER)) begin
                    n_rv = add_sum;
                end else begin
                    n_rv = add_a;
                end
            end
            ST_RESP: begin
                n_out.entry_index = r_idx;
                n_out.read_value  = r_rv;
                n_out.status      = r_status;
                n_out.matrix_size = r_size;
                n_out.entry_count = r_count;
                n_out_vld         = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_size    <= '0;
            r_sym     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_size    <= n_size;
            r_sym     <= n_sym;
            r_out_vld <= n_out_vld;
        end
    end

    // hold payload
    always_ff @(posedge i_clk) begin
        r_in      <= n_in;
        r_ptr     <= n_ptr;
        r_pos     <= n_pos;
        r_created <= n_created;
        r_status  <= n_status;
        r_idx     <= n_idx;
        r_rv      <= n_rv;
        r_out     <= n_out;
    end

    // key memory: write on create, read during the scan
    always_ff @(posedge i_clk) begin
        if (key_we) key_mem[r_count[ADDR_W-1:0]] <= key;
        if (r_state == ST_KEY_RD) r_key_rd <= key_mem[r_ptr[ADDR_W-1:0]];
    end

    // value memory: read on hit, write back the updated value
    always_ff @(posedge i_clk) begin
        if (val_we) val_mem[r_pos[ADDR_W-1:0]] <= n_rv;
        if (r_state == ST_VAL_RD) r_mem_val <= val_mem[r_pos[ADDR_W-1:0]];
    end

endmodule

/* hdl/sca_checker.sv */
// Port-level assertions for the sparse coordinate assembly table, bound to the top level.
module sca_checker
    import sca_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input logic      o_done,
    input t_result   o_result
);

    // accepted item keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but block not busy");

    // a result follows only from work in progress
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without an item in work");

    // results that store nothing report zero index and value
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status == STS_ABSENT || o_result.status == STS_FULL ||
                    o_result.status == STS_FILTERED))
        |-> (o_result.entry_index == '0 && o_result.read_value == '0))
        else $error("nonzero fields on a result that stores nothing");

    // empty profile has zero size
    a_empty_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.entry_count == '0) |-> (o_result.matrix_size == '0))
        else $error("empty profile with nonzero size");

    // created entry is the last one
    a_created_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == STS_CREATED)
        |-> (CNT_W'(o_result.entry_index) + CNT_W'(1) == o_result.entry_count))
        else $error("created entry is not the newest");

endmodule

bind sparse_coo_assembly_table_core sca_checker u_sca_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

/* dv/tb_sparse_coo_assembly_table_core.sv */
// Self-checking testbench for the sparse coordinate assembly table core.
module tb_sparse_coo_assembly_table_core;
    import sca_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic signed [VAL_W-1:0] Q_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] Q_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] Q_ONE = 64'sh0000_0001_0000_0000;
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_MID   = 3'd6;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
    localparam int         IDLE_PCT        = 24;
    localparam int         RANDOM_ITEMS    = 200;
    localparam int         BUSY_CAP        = 48;
    localparam int         TAIL_CYCLES     = 2200;
    localparam longint     LIMIT_NS        = 64'd14_000_000;

    typedef enum logic [1:0] {
        OP_ITEM,
        OP_CFG,
        OP_DRAIN
    } t_op_kind;

    typedef struct packed {
        t_op_kind  kind;
        t_cmd_item item;
        logic      sym;
    } t_plan_op;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      start     = 1'b0;
    logic      busy;
    t_cmd_item cmd_item  = '0;
    logic      done;
    t_result   result;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_sym   = 1'b0;

    // planned items and register writes, and results still owed by the block
    t_plan_op    cmd_plan[$];
    t_result     due_results[$];
    logic [31:0] plan_coords[$];

    // predicted profile contents
    logic [KEY_W-1:0]        prof_key [CAPACITY];
    logic signed [VAL_W-1:0] prof_sum [CAPACITY];
    int                      prof_count = 0;
    logic [SIZE_W-1:0]       prof_size  = '0;
    logic                    sym_mode   = 1'b0;

    int unsigned acc_cnt  = 0;
    int unsigned hold_cnt = 0;
    int          fail_cnt = 0;

    sparse_coo_assembly_table_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (cmd_item),
        .o_done      (done),
        .o_result    (result),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_sym)
    );

    always #1 clk = ~clk;

    // Q32.32 add, clamped at the representable limits
    function automatic logic signed [VAL_W-1:0] sat_accum(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic signed [VAL_W-1:0] s;
        s = a + b;
        if (a[VAL_W-1] == b[VAL_W-1] && s[VAL_W-1] != a[VAL_W-1])
            return a[VAL_W-1] ? Q_MIN : Q_MAX;
        return s;
    endfunction

    function automatic bit find_coord(input logic [KEY_W-1:0] key, output int pos);
        pos = 0;
        for (int k = 0; k < prof_count; k++) begin
            if (prof_key[k] == key) begin
                pos = k;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // advance the predicted profile by one item and return its result
    function automatic t_result profile_step(input t_cmd_item it);
        t_result           res;
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] r1;
        logic [SIZE_W-1:0] c1;
        int                pos;
        bit                keep;
        res        = '0;
        res.status = STS_FILTERED;
        key        = {it.row, it.col};
        r1         = SIZE_W'(it.row) + SIZE_W'(1);
        c1         = SIZE_W'(it.col) + SIZE_W'(1);
        case (it.command)
            CMD_INSERT, CMD_INSERT_ADD: begin
                if (find_coord(key, pos)) begin
                    res.status = STS_FOUND;
                end else if (prof_count < CAPACITY) begin
                    pos           = prof_count;
                    prof_key[pos] = key;
                    prof_sum[pos] = '0;
                    prof_count++;
                    if (r1 > prof_size) prof_size = r1;
                    if (c1 > prof_size) prof_size = c1;
                    res.status = STS_CREATED;
                end else begin
                    res.status = STS_FULL;
                end
                if (res.status != STS_FULL) begin
                    if (it.command == CMD_INSERT_ADD)
                        prof_sum[pos] = sat_accum(prof_sum[pos], it.value);
                    res.entry_index = ADDR_W'(pos);
                    res.read_value  = prof_sum[pos];
                end
            end
            CMD_READ: begin
                if (find_coord(key, pos)) begin
                    res.status      = STS_FOUND;
                    res.entry_index = ADDR_W'(pos);
                    res.read_value  = prof_sum[pos];
                end else begin
                    res.status = STS_ABSENT;
                end
            end
            CMD_CLEAR: begin
                prof_count = 0;
                prof_size  = '0;
                res.status = STS_FOUND;
            end
            CMD_SCATTER: begin
                keep = (SIZE_W'(it.row) < prof_size) && (SIZE_W'(it.col) < prof_size);
                if (keep && sym_mode) begin
                    if (it.values_symmetric) keep = (it.local_col >= it.local_row);
                    else keep = (it.col >= it.row);
                end
                if (!keep) begin
                    res.status = STS_FILTERED;
                end else if (find_coord(key, pos)) begin
                    prof_sum[pos]   = sat_accum(prof_sum[pos], it.value);
                    res.status      = STS_FOUND;
                    res.entry_index = ADDR_W'(pos);
                    res.read_value  = prof_sum[pos];
                end else begin
                    res.status = STS_ABSENT;
                end
            end
            default: res.status = STS_FILTERED;
        endcase
        res.matrix_size = prof_size;
        res.entry_count = CNT_W'(prof_count);
        return res;
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_q32();
        logic [31:0] v32;
        v32 = $urandom;
        case ($urandom_range(9))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2, 3:    return {{32{v32[31]}}, v32};
            default: return {$urandom, v32};
        endcase
    endfunction

    // mostly small indices so sizes stay modest, with the full range now and then
    function automatic logic [15:0] rand_index();
        int sel;
        sel = $urandom_range(9);
        if (sel < 5) return 16'($urandom_range(15));
        if (sel < 8) return 16'($urandom_range(255));
        if (sel < 9) return 16'($urandom);
        return 16'hFFFF;
    endfunction

    task automatic push_cmd(
        input logic [2:0]              cmd,
        input logic [15:0]             row,
        input logic [15:0]             col,
        input logic signed [VAL_W-1:0] value,
        input logic [3:0]              lr,
        input logic [3:0]              lc,
        input logic                    vs
    );
        t_plan_op op;
        bit       known;
        op.kind                  = OP_ITEM;
        op.sym                   = 1'b0;
        op.item.command          = cmd;
        op.item.row              = row;
        op.item.col              = col;
        op.item.value            = value;
        op.item.local_row        = lr;
        op.item.local_col        = lc;
        op.item.values_symmetric = vs;
        cmd_plan.insert(cmd_plan.size(), op);
        // track which pairs will exist, so later items can target them
        if (cmd == CMD_INSERT || cmd == CMD_INSERT_ADD) begin
            known = 1'b0;
            foreach (plan_coords[j])
                if (plan_coords[j] == {row, col}) known = 1'b1;
            if (!known && plan_coords.size() < CAPACITY)
                plan_coords.insert(plan_coords.size(), {row, col});
        end else if (cmd == CMD_CLEAR) begin
            plan_coords.delete();
        end
    endtask

    task automatic push_ctl(input t_op_kind kind, input logic sym);
        t_plan_op op;
        op      = '0;
        op.kind = kind;
        op.sym  = sym;
        cmd_plan.insert(cmd_plan.size(), op);
    endtask

    task automatic cmp_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %h, actual %h", name, want, got);
            fail_cnt++;
        end
    endtask

    // Driver: present planned items, write the register only when the block is drained
    always @(posedge clk) begin : drive_proc
        logic     nxt_start;
        logic     nxt_cfg;
        t_plan_op op;
        if (rst_n) begin
            nxt_start = start;
            nxt_cfg   = cfg_valid;
            if (start && !busy) begin
                due_results.insert(due_results.size(), profile_step(cmd_item));
                acc_cnt++;
                nxt_start = 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                sym_mode = cfg_sym;
                nxt_cfg  = 1'b0;
            end
            if (!nxt_start && !nxt_cfg && cmd_plan.size() != 0) begin
                op = cmd_plan[0];
                case (op.kind)
                    OP_ITEM: begin
                        if (hold_cnt != 0) begin
                            hold_cnt--;
                        end else if (!(acc_cnt >= 400 && acc_cnt < 700) &&
                                     $urandom_range(99) < IDLE_PCT) begin
                            hold_cnt = ($urandom_range(3) == 0) ? $urandom_range(40, 1) : 0;
                        end else begin
                            cmd_item  <= op.item;
                            nxt_start = 1'b1;
                            void'(cmd_plan.pop_front());
                        end
                    end
                    default: begin
                        // hold until every owed result is in and none is on the port
                        if (due_results.size() == 0 && !done) begin
                            if (op.kind == OP_CFG) begin
                                cfg_sym <= op.sym;
                                nxt_cfg = 1'b1;
                            end
                            void'(cmd_plan.pop_front());
                        end
                    end
                endcase
            end
            start     <= nxt_start;
            cfg_valid <= nxt_cfg;
        end
    end

    // Monitor: compare each strobed result with the oldest prediction
    always @(posedge clk) begin : check_proc
        t_result want;
        if (rst_n && done) begin
            if (due_results.size() == 0) begin
                $error("result with no item outstanding, status %0d", result.status);
                fail_cnt++;
            end else begin
                want = due_results.pop_front();
                cmp_field("entry_index", 64'(want.entry_index), 64'(result.entry_index));
                cmp_field("read_value", want.read_value, result.read_value);
                cmp_field("status", 64'(want.status), 64'(result.status));
                cmp_field("matrix_size", 64'(want.matrix_size), 64'(result.matrix_size));
                cmp_field("entry_count", 64'(want.entry_count), 64'(result.entry_count));
            end
        end
    end

    initial begin : limit_proc
        #(LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : plan_proc
        int          sel;
        logic [31:0] pick;
        logic [15:0] row;
        logic [15:0] col;
        logic [2:0]  cmd;

        // directed: empty table, saturation, spare codes, both register settings
        push_ctl(OP_CFG, 1'b0);
        push_cmd(CMD_READ, 16'd0, 16'd0, '0, 4'd0, 4'd0, 1'b0);
        push_cmd(CMD_SCATTER, 16'd0, 16'd0, Q_ONE, 4'd0, 4'd0, 1'b0);
        push_cmd(CMD_INSERT, 16'd0, 16'd0, Q_MAX, 4'd15, 4'd15, 1'b1);
        push_cmd(CMD_INSERT, 16'd0, 16'd0, '0, 4'd0, 4'd0, 1'b0);
        push_cmd(CMD_INSERT_ADD, 16'hFFFF, 16'hFFFF, Q_MAX, 4'd0, 4'd0, 1'b0);
        push_cmd(CMD_INSERT_ADD, 16'hFFFF, 16'hFFFF, Q_MAX, 4'd0, 4'd0, 1'b0);
        push_cmd(CMD_INSERT_ADD, 16'd0, 16'd0, Q_MIN, 4'd0, 4'd0, 1'b0);
        push_cmd(CMD_INSERT_ADD, 16'd0, 16'd0, Q_MIN, 4'd0, 4'd0, 1'b0);
        push_cmd(CMD_INSERT_ADD, 16'd3, 16'd7, Q_ONE, 4'd0, 4'd0, 1'b0);
        push_cmd(CMD_SCATTER, 16'd3, 16'd7, -Q_ONE, 4'd0, 4'd0, 1'b0);
        push_cmd(CMD_SCATTER, 16'd7, 16'd3, Q_ONE, 4'd0, 4'd0, 1'b0);
        push_cmd(CMD_SPARE_FIRST, 16'hFFFF, 16'd0, Q_MAX, 4'd15, 4'd0, 1'b1);
        push_cmd(CMD_SPARE_MID, 16'd0, 16'hFFFF, Q_MIN, 4'd0, 4'd15, 1'b0);
        push_cmd(CMD_SPARE_LAST, 16'hFFFF, 16'hFFFF, -Q_ONE, 4'd15, 4'd15, 1'b1);
        push_ctl(OP_CFG, 1'b1);
        push_cmd(CMD_SCATTER, 16'd7, 16'd3, Q_ONE, 4'd0, 4'd0, 1'b0);
        push_cmd(CMD_INSERT, 16'd7, 16'd3, '0, 4'd0, 4'd0, 1'b0);
        push_cmd(CMD_SCATTER, 16'd7, 16'd3, Q_ONE, 4'd0, 4'd15, 1'b1);
        push_cmd(CMD_SCATTER, 16'd3, 16'd7, Q_ONE, 4'd15, 4'd0, 1'b1);
        push_cmd(CMD_CLEAR, 16'd0, 16'd0, '0, 4'd0, 4'd0, 1'b0);
        push_cmd(CMD_INSERT, 16'd2, 16'd5, '0, 4'd0, 4'd0, 1'b0);
        push_cmd(CMD_SCATTER, 16'd6, 16'd2, Q_ONE, 4'd0, 4'd0, 1'b0);
        push_cmd(CMD_READ, 16'd2, 16'd5, '0, 4'd0, 4'd0, 1'b0);
        push_cmd(CMD_CLEAR, 16'd0, 16'd0, '0, 4'd0, 4'd0, 1'b0);
        push_ctl(OP_CFG, 1'b0);

        // random: mostly operations on pairs that exist, with a small profile
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 80 == 79) push_ctl(OP_CFG, 1'($urandom_range(1)));
            if (i % 100 == 50) push_ctl(OP_DRAIN, 1'b0);
            sel = $urandom_range(99);
            row = rand_index();
            col = rand_index();
            if (plan_coords.size() != 0) begin
                pick = plan_coords[$urandom_range(plan_coords.size() - 1)];
                if (sel >= 20 && sel < 45 || sel >= 50 && sel < 85) begin
                    row = pick[31:16];
                    col = pick[15:0];
                end
            end
            if (plan_coords.size() > BUSY_CAP || (sel >= 92 && sel < 95))
                cmd = CMD_CLEAR;
            else if (sel < 35)
                cmd = $urandom_range(1) ? CMD_INSERT_ADD : CMD_INSERT;
            else if (sel < 50)
                cmd = CMD_READ;
            else if (sel < 92)
                cmd = CMD_SCATTER;
            else
                cmd = 3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
            push_cmd(cmd, row, col, rand_q32(), 4'($urandom), 4'($urandom),
                     1'($urandom_range(1)));
        end

        // fill the profile to capacity, then probe the full table
        push_ctl(OP_CFG, 1'($urandom_range(1)));
        push_cmd(CMD_CLEAR, 16'd0, 16'd0, '0, 4'd0, 4'd0, 1'b0);
        for (int k = 0; k < CAPACITY; k++) begin
            col = 16'($urandom);
            push_cmd((k % 2 != 0) ? CMD_INSERT_ADD : CMD_INSERT, 16'(k * 61), col,
                     rand_q32(), 4'($urandom), 4'($urandom), 1'($urandom_range(1)));
        end
        push_cmd(CMD_INSERT, 16'd1, 16'd1, Q_ONE, 4'd0, 4'd0, 1'b0);
        push_cmd(CMD_INSERT_ADD, 16'((CAPACITY - 1) * 61), col, Q_MAX, 4'd0, 4'd0, 1'b0);
        push_cmd(CMD_SCATTER, 16'((CAPACITY - 1) * 61), col, Q_ONE, 4'd0, 4'd15, 1'b1);
        push_cmd(CMD_READ, 16'd1, 16'd1, '0, 4'd0, 4'd0, 1'b0);
        push_cmd(CMD_SCATTER, 16'd1, 16'd2, Q_ONE, 4'd0, 4'd0, 1'b0);
        push_cmd(CMD_CLEAR, 16'd0, 16'd0, '0, 4'd0, 4'd0, 1'b0);
        push_cmd(CMD_READ, 16'd0, 16'd0, '0, 4'd0, 4'd0, 1'b0);

        // release reset and let the driver work through the plan
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        while (cmd_plan.size() != 0 || start || cfg_valid) @(posedge clk);
        while (due_results.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
